@@ sv/lcfm_pkg.sv @@
`default_nettype none
package lcfm_pkg;
  localparam logic [1:0] ReqTick = 2'd0;
  localparam logic [1:0] ReqBriSet = 2'd1;
  localparam logic [1:0] ReqCtSet = 2'd2;
  localparam logic [1:0] ReqCtNow = 2'd3;

  localparam logic CfgMinMired = 1'b0;
  localparam logic CfgMaxMired = 1'b1;

  localparam logic [15:0] MiredReset = 16'd300;
  localparam logic [15:0] MinMiredReset = 16'd200;
  localparam logic [15:0] MaxMiredReset = 16'd455;
  localparam logic [19:0] MixNumer = 20'd1000000;
  localparam logic [12:0] KelvinLo = 13'd2200;
  localparam logic [12:0] KelvinHi = 13'd5000;
  // ceil(2^31 / 175): (k - 2200) * 65536 / 2800 becomes a multiply and a shift by 19
  localparam logic [23:0] RatioRecip = 24'd12271336;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  level;
    logic [15:0] mired;
    logic [15:0] fade_ms;
    logic [15:0] fallback_mired;
  } req_t;

  typedef struct packed {
    logic [7:0]  amber_duty;
    logic [7:0]  white_duty;
    logic        applied;
    logic [7:0]  level_now;
    logic [15:0] ct_mired;
    logic        fade_busy;
  } rsp_t;

  // front-end classified item; ct_target holds the mired clamped to the configured limits
  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  level;
    logic [15:0] mired;
    logic [15:0] ct_target;
    logic [15:0] duration;
    logic [15:0] fallback_mired;
  } cmd_t;
endpackage
`default_nettype wire

@@ sv/lcfm_if.sv @@
`default_nettype none
interface lcfm_req_if;
  logic            valid;
  logic            ready;
  lcfm_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lcfm_rsp_if;
  logic            valid;
  logic            ready;
  lcfm_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/lcfm_front.sv @@
`default_nettype none
module lcfm_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_idx_i,
  input  wire logic [15:0]     cfg_data_i,
  input  wire logic            cfg_valid_idx_i,
  lcfm_req_if.sink             req,
  output lcfm_pkg::cmd_t       cmd_o,
  output logic                 cmd_valid_o,
  input  wire logic            cmd_ready_i
);
  logic [15:0] min_q, max_q, clamped, lo;
  lcfm_pkg::cmd_t cmd_q;
  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= lcfm_pkg::MinMiredReset;
      max_q <= lcfm_pkg::MaxMiredReset;
    end else if (cfg_we_i && cfg_valid_idx_i) begin
      if (cfg_idx_i == lcfm_pkg::CfgMinMired) min_q <= cfg_data_i;
      else max_q <= cfg_data_i;
    end
  end

  always_comb begin
    lo = (req.data.mired < min_q) ? min_q : req.data.mired;
    clamped = (lo > max_q) ? max_q : lo;
  end

  // single-entry queue toward the back end
  assign req.ready = !valid_q || cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (req.ready) valid_q <= req.valid;
  end

  always_ff @(posedge clk_i) begin
    if (req.ready && req.valid) begin
      cmd_q.req_type <= req.data.req_type;
      cmd_q.level <= req.data.level;
      cmd_q.mired <= req.data.mired;
      cmd_q.ct_target <= clamped;
      cmd_q.duration <= (req.data.fade_ms == 16'd0) ? 16'd1 : req.data.fade_ms;
      cmd_q.fallback_mired <= req.data.fallback_mired;
    end
  end

  assign cmd_o = cmd_q;
  assign cmd_valid_o = valid_q;
endmodule
`default_nettype wire

@@ sv/lcfm_div.sv @@
`default_nettype none
// restoring unsigned divider, one quotient bit per cycle
module lcfm_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [23:0] num_i,
  input  wire logic [15:0] den_i,
  output logic             done_o,
  output logic [23:0]      quo_o
);
  logic [23:0] quo_q;
  logic [16:0] rem_q;
  logic [15:0] den_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [16:0] sh;
  logic        ge;

  assign sh = {rem_q[15:0], quo_q[23]};
  assign ge = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 5'd0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 5'd23;
      end else if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= 17'd0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? (sh - {1'b0, den_q}) : sh;
      quo_q <= {quo_q[22:0], ge};
    end
  end
  assign quo_o = quo_q;
endmodule
`default_nettype wire

@@ sv/lcfm_back.sv @@
`default_nettype none
module lcfm_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  lcfm_pkg::cmd_t       cmd_i,
  input  wire logic            cmd_valid_i,
  output logic                 cmd_ready_o,
  lcfm_rsp_if.source           rsp
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SStep = 3'd1;
  localparam logic [2:0] SKel = 3'd2;
  localparam logic [2:0] SMul = 3'd4;
  localparam logic [2:0] SOut = 3'd5;

  logic [2:0]  st_q;
  logic [7:0]  lcur_q, ltgt_q, amb_q, wht_q;
  logic        lrun_q, crun_q, appl_q;
  logic [15:0] rend_q, ccur_q, ctgt_q, cdur_q;
  logic        tick_q;
  logic [16:0] r_q;

  logic        div_start, div_done;
  logic [23:0] div_num, div_quo;
  logic [15:0] div_den;

  lcfm_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  logic        lmove, cmove, up;
  logic [15:0] steps, diffm, nxt, mixm;
  logic [12:0] kel, kdiff;
  logic [36:0] rprod;
  logic [16:0] rr;

  always_comb begin
    lmove = lrun_q && (lcur_q != ltgt_q);
    cmove = crun_q && (ccur_q != ctgt_q);
    up = ctgt_q > ccur_q;
    diffm = up ? (ctgt_q - ccur_q) : (ccur_q - ctgt_q);
    steps = (cdur_q[15:1] == 15'd0) ? 16'd1 : {1'b0, cdur_q[15:1]};
    mixm = (ccur_q == 16'd0) ? 16'd1 : ccur_q;
    // quotient never exceeds diff, so no overshoot beyond the target
    if (div_quo[15:0] == 16'd0) nxt = up ? ccur_q + 16'd1 : ccur_q - 16'd1;
    else nxt = up ? ccur_q + div_quo[15:0] : ccur_q - div_quo[15:0];
    if (div_quo > 24'd5000) kel = lcfm_pkg::KelvinHi;
    else if (div_quo[12:0] < lcfm_pkg::KelvinLo) kel = lcfm_pkg::KelvinLo;
    else kel = div_quo[12:0];
    kdiff = kel - lcfm_pkg::KelvinLo;
    // cool ratio by reciprocal, exact for kdiff in 0..2800
    rprod = {24'd0, kdiff} * {13'd0, lcfm_pkg::RatioRecip};
    rr = r_q;
    div_start = 1'b0;
    div_num = 24'd0;
    div_den = 16'd1;
    case (st_q)
      SIdle: begin
        if (cmd_valid_i && !rsp.valid && cmd_i.req_type == lcfm_pkg::ReqTick && cmove) begin
          div_start = 1'b1;
          div_num = {8'd0, diffm};
          div_den = steps;
        end
      end
      SStep: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num = {4'd0, lcfm_pkg::MixNumer};
          div_den = (nxt == 16'd0) ? 16'd1 : nxt;
        end
      end
      SKel: begin
        if (tick_q) begin
          div_start = 1'b1;
          div_num = {4'd0, lcfm_pkg::MixNumer};
          div_den = mixm;
        end
      end
      default: ;
    endcase
  end

  assign cmd_ready_o = (st_q == SOut) && !rsp.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      lcur_q <= 8'd0; ltgt_q <= 8'd0; lrun_q <= 1'b0;
      rend_q <= lcfm_pkg::MiredReset; ccur_q <= lcfm_pkg::MiredReset;
      ctgt_q <= lcfm_pkg::MiredReset; cdur_q <= lcfm_pkg::MiredReset;
      crun_q <= 1'b0; amb_q <= 8'd0; wht_q <= 8'd0; appl_q <= 1'b0;
      tick_q <= 1'b0;
      r_q <= 17'd0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      case (st_q)
        SIdle: begin
          if (cmd_valid_i && !rsp.valid) begin
            appl_q <= 1'b0;
            st_q <= SOut;
            case (cmd_i.req_type)
              lcfm_pkg::ReqTick: begin
                if (lmove) lcur_q <= (lcur_q < ltgt_q) ? lcur_q + 8'd1 : lcur_q - 8'd1;
                else lrun_q <= 1'b0;
                if (!cmove) crun_q <= 1'b0;
                if (cmove) st_q <= SStep;
                else if (lmove) begin
                  st_q <= SKel;
                  tick_q <= 1'b1;
                end
              end
              lcfm_pkg::ReqBriSet: begin
                if (!lrun_q) lcur_q <= (amb_q > wht_q) ? amb_q : wht_q;
                ltgt_q <= cmd_i.level;
                rend_q <= cmd_i.mired;
                lrun_q <= 1'b1;
              end
              lcfm_pkg::ReqCtSet: begin
                ctgt_q <= cmd_i.ct_target;
                cdur_q <= cmd_i.duration;
                crun_q <= 1'b1;
                if (!crun_q) begin
                  ccur_q <= (rend_q == 16'd0) ? cmd_i.fallback_mired : rend_q;
                  rend_q <= (rend_q == 16'd0) ? cmd_i.fallback_mired : rend_q;
                end else rend_q <= ccur_q;
              end
              default: begin
                ccur_q <= cmd_i.ct_target;
                ctgt_q <= cmd_i.ct_target;
                rend_q <= cmd_i.ct_target;
                crun_q <= 1'b0;
                st_q <= SKel;
                tick_q <= 1'b1;
              end
            endcase
          end
        end
        SStep: begin
          if (div_done) begin
            ccur_q <= nxt;
            st_q <= SKel;
          end
        end
        SKel: begin
          // from idle, tick_q marks the first cycle and starts the kelvin division
          if (tick_q) tick_q <= 1'b0;
          else if (div_done) begin
            r_q <= rprod[35:19];
            st_q <= SMul;
          end
        end
        SMul: begin
          wht_q <= 8'(({8'd0, lcur_q} * {7'd0, rr}) >> 16);
          amb_q <= 8'(({8'd0, lcur_q} * (25'd65536 - {8'd0, rr})) >> 16);
          rend_q <= ccur_q;
          appl_q <= 1'b1;
          st_q <= SOut;
        end
        SOut: begin
          if (!rsp.valid) begin
            rsp.valid <= 1'b1;
            st_q <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  assign rsp.data = lcfm_pkg::rsp_t'{amber_duty: amb_q, white_duty: wht_q, applied: appl_q,
                                     level_now: lcur_q, ct_mired: ccur_q,
                                     fade_busy: lrun_q || crun_q};
endmodule
`default_nettype wire

@@ sv/led_cct_fade_mixer.sv @@
`default_nettype none
// Warm/cool white fade and mix engine. One result per request. Requests that
// only update state skip the divider; a tick or immediate ct set that remixes
// runs the shared 24-step divider for the kelvin division (plus one more division
// for the ct step on a moving ct fade) and gets the cool ratio from a reciprocal
// multiply.
// A one-entry queue separates request decode and clamping from execution.
module led_cct_fade_mixer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  lcfm_req_if.sink         req,
  lcfm_rsp_if.source       rsp
);
  lcfm_pkg::cmd_t cmd;
  logic cmd_valid, cmd_ready;

  lcfm_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i(cfg_idx_i[0]), .cfg_data_i,
    .cfg_valid_idx_i(1'b1), .req,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  lcfm_back u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready), .rsp
  );
endmodule
`default_nettype wire

@@ sim/led_cct_fade_mixer_test.sv @@
`default_nettype none
module led_cct_fade_mixer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  lcfm_req_if req_ch ();
  lcfm_rsp_if rsp_ch ();

  led_cct_fade_mixer dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [15:0] lo_mired, hi_mired;
  logic [7:0] bri_cur, bri_goal;
  logic bri_moving, ct_moving;
  logic [15:0] shown_mired, ct_now, ct_goal, ct_len;
  logic [7:0] amber_q, white_q;

  lcfm_pkg::rsp_t duty_queue[$];
  int errors = 0, sent = 0, seen = 0, remixes = 0, stall_pct = 28, idle_cycles = 0;
  bit flood = 1'b0;

  function automatic void reset_model();
    lo_mired = lcfm_pkg::MinMiredReset; hi_mired = lcfm_pkg::MaxMiredReset;
    bri_cur = '0; bri_goal = '0; bri_moving = 1'b0;
    shown_mired = lcfm_pkg::MiredReset; ct_now = lcfm_pkg::MiredReset;
    ct_goal = lcfm_pkg::MiredReset;
    ct_len = lcfm_pkg::MiredReset; ct_moving = 1'b0; amber_q = '0; white_q = '0;
  endfunction

  function automatic void remix(logic [7:0] bri, logic [15:0] m);
    logic [31:0] k, r, mm;
    mm = (m == 0) ? 32'd1 : 32'(m);
    k = 32'd1000000 / mm;
    if (k < 2200) k = 2200;
    if (k > 5000) k = 5000;
    r = ((k - 2200) << 16) / 2800;
    white_q = 8'((32'(bri) * r) >> 16);
    amber_q = 8'((32'(bri) * (32'd65536 - r)) >> 16);
  endfunction

  function automatic logic [15:0] limit_ct(logic [15:0] v);
    if (v < lo_mired) v = lo_mired;
    if (v > hi_mired) v = hi_mired;
    return v;
  endfunction

  function automatic lcfm_pkg::rsp_t predict_duty(lcfm_pkg::req_t q);
    lcfm_pkg::rsp_t o;
    logic hit;
    int steps, diff, stp, nxt;
    logic [15:0] t, d;
    hit = 1'b0;
    case (q.req_type)
      lcfm_pkg::ReqTick: begin
        logic moved;
        moved = 1'b0;
        if (bri_moving && bri_cur != bri_goal) begin
          bri_cur = (bri_cur < bri_goal) ? bri_cur + 8'd1 : bri_cur - 8'd1;
          moved = 1'b1;
        end else bri_moving = 1'b0;
        if (ct_moving && ct_now != ct_goal) begin
          steps = int'(ct_len / 2);
          if (steps < 1) steps = 1;
          diff = int'(ct_goal) - int'(ct_now);
          stp = diff / steps;
          if (stp == 0) stp = (diff > 0) ? 1 : -1;
          nxt = int'(ct_now) + stp;
          if ((diff > 0 && nxt > int'(ct_goal)) || (diff < 0 && nxt < int'(ct_goal)))
            nxt = int'(ct_goal);
          ct_now = 16'(nxt);
          moved = 1'b1;
        end else ct_moving = 1'b0;
        if (moved) begin
          remix(bri_cur, ct_now);
          shown_mired = ct_now;
          hit = 1'b1;
        end
      end
      lcfm_pkg::ReqBriSet: begin
        if (!bri_moving) bri_cur = (amber_q > white_q) ? amber_q : white_q;
        bri_goal = q.level; shown_mired = q.mired; bri_moving = 1'b1;
      end
      lcfm_pkg::ReqCtSet: begin
        t = limit_ct(q.mired);
        d = (q.fade_ms == 0) ? 16'd1 : q.fade_ms;
        if (!ct_moving) begin
          ct_now = shown_mired;
          if (ct_now == 0) ct_now = q.fallback_mired;
        end
        ct_goal = t; ct_len = d; ct_moving = 1'b1; shown_mired = ct_now;
      end
      default: begin
        t = limit_ct(q.mired);
        ct_now = t; ct_goal = t; ct_moving = 1'b0; shown_mired = t;
        remix(bri_cur, t);
        hit = 1'b1;
      end
    endcase
    o.amber_duty = amber_q; o.white_duty = white_q; o.applied = hit;
    o.level_now = bri_cur; o.ct_mired = ct_now; o.fade_busy = bri_moving | ct_moving;
    return o;
  endfunction

  // result side: random stall, check against oldest expectation
  always @(posedge clk_i) begin
    if (!rst_ni) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= flood || ($urandom_range(99) >= stall_pct);
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      lcfm_pkg::rsp_t e;
      seen++;
      idle_cycles = 0;
      if (duty_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, rsp_ch.data);
      end else begin
        e = duty_queue.pop_front();
        if (rsp_ch.data !== e) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, e, rsp_ch.data);
        end
      end
    end else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("led_cct_fade_mixer_test: FAIL");
      $finish;
    end
  end

  task automatic send_req(lcfm_pkg::req_t q);
    lcfm_pkg::rsp_t e;
    bit acc;
    do @(posedge clk_i); while (!flood && $urandom_range(99) < stall_pct);
    req_ch.valid <= 1'b1;
    req_ch.data <= q;
    // ready only moves at clock edges, so the mid-cycle value holds at the next edge
    do begin
      @(negedge clk_i);
      acc = req_ch.ready;
      @(posedge clk_i);
    end while (!acc);
    e = predict_duty(q);
    if (e.applied) remixes++;
    duty_queue.push_back(e);
    sent++;
    req_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (duty_queue.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == lcfm_pkg::CfgMinMired) lo_mired = val; else hi_mired = val;
  endtask

  function automatic lcfm_pkg::req_t mk(logic [1:0] t, logic [7:0] l, logic [15:0] m,
                                        logic [15:0] d, logic [15:0] f);
    lcfm_pkg::req_t q;
    q.req_type = t; q.level = l; q.mired = m; q.fade_ms = d; q.fallback_mired = f;
    return q;
  endfunction

  function automatic lcfm_pkg::req_t rand_req();
    int p;
    p = $urandom_range(99);
    if (p < 55)
      return mk(lcfm_pkg::ReqTick, 8'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    if (p < 72)
      return mk(lcfm_pkg::ReqBriSet, 8'($urandom), ($urandom_range(9) == 0) ? 16'd0 :
                16'($urandom_range(150, 500)), 16'($urandom), 16'($urandom));
    if (p < 90)
      return mk(lcfm_pkg::ReqCtSet, 8'($urandom), ($urandom_range(4) == 0) ?
                16'($urandom) : 16'($urandom_range(100, 600)),
                ($urandom_range(3) == 0) ? 16'($urandom) :
                16'($urandom_range(0, 40)), 16'($urandom));
    return mk(lcfm_pkg::ReqCtNow, 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
  endfunction

  // directed rows: stimulus plus expected result where obvious
  typedef struct {
    lcfm_pkg::req_t q;
    bit known;
    lcfm_pkg::rsp_t want;
  } row_t;

  row_t rows[$];

  initial begin
    row_t r;
    lcfm_pkg::rsp_t got;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    reset_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    r.known = 1'b1;
    r.q = mk(lcfm_pkg::ReqTick, 8'hff, 16'hffff, 16'hffff, 16'hffff);
    r.want = '{8'd0, 8'd0, 1'b0, 8'd0, 16'd300, 1'b0};
    rows.push_back(r);
    r.known = 1'b0;
    r.q = mk(lcfm_pkg::ReqBriSet, 8'd255, 16'd0, 16'd0, 16'd0); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqTick, '0, '0, '0, '0); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqTick, '0, '0, '0, '0); rows.push_back(r);
    // immediate set to zero mired clamps to min
    r.q = mk(lcfm_pkg::ReqCtNow, '0, 16'd0, '0, '0); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqCtNow, '0, 16'hffff, '0, '0); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqCtSet, '0, 16'd200, 16'd0, 16'd0); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqTick, '0, '0, '0, '0); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqTick, '0, '0, '0, '0); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqTick, '0, '0, '0, '0); rows.push_back(r);
    // render mired zero makes ct set use fallback
    r.q = mk(lcfm_pkg::ReqBriSet, 8'd0, 16'd0, '0, '0); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqCtSet, '0, 16'd455, 16'hffff, 16'd1000); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqTick, '0, '0, '0, '0); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqCtSet, '0, 16'd300, 16'd4, 16'hffff); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqTick, '0, '0, '0, '0); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqTick, '0, '0, '0, '0); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqTick, '0, '0, '0, '0); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqBriSet, 8'd128, 16'd250, '0, '0); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqTick, '0, '0, '0, '0); rows.push_back(r);
    // bri set to render mired zero again, then a tick
    r.q = mk(lcfm_pkg::ReqBriSet, 8'd200, 16'd0, '0, '0); rows.push_back(r);
    r.q = mk(lcfm_pkg::ReqTick, '0, '0, '0, '0); rows.push_back(r);
    foreach (rows[i]) begin
      send_req(rows[i].q);
      if (rows[i].known) begin
        got = duty_queue[$];
        if (got !== rows[i].want) begin
          errors++;
          $display("%0t: table row %0d expected %h actual %h", $time, i,
                   rows[i].want, got);
        end
      end
    end
    drain();

    // crossed limits: max wins
    write_reg(lcfm_pkg::CfgMinMired, 16'd500);
    write_reg(lcfm_pkg::CfgMaxMired, 16'd150);
    send_req(mk(lcfm_pkg::ReqCtNow, '0, 16'd300, '0, '0));
    send_req(mk(lcfm_pkg::ReqCtSet, '0, 16'd1, 16'd2, '0));
    repeat (3) send_req(mk(lcfm_pkg::ReqTick, '0, '0, '0, '0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(lcfm_pkg::CfgMinMired, 16'd1);
          write_reg(lcfm_pkg::CfgMaxMired, 16'hffff);
        end
        1: begin
          write_reg(lcfm_pkg::CfgMinMired, 16'hffff);
          write_reg(lcfm_pkg::CfgMaxMired, 16'hffff);
        end
        2: begin
          write_reg(lcfm_pkg::CfgMinMired, 16'd1);
          write_reg(lcfm_pkg::CfgMaxMired, 16'd1);
        end
        default: begin
          write_reg(lcfm_pkg::CfgMinMired, 16'($urandom_range(1, 400)));
          write_reg(lcfm_pkg::CfgMaxMired, 16'($urandom_range(150, 700)));
        end
      endcase
      flood = (ph == 3);
      for (int n = 0; n < 190; n++) begin
        send_req(rand_req());
        if (n == 95 && ph == 4) begin
          while (duty_queue.size() != 0) @(posedge clk_i);
        end
      end
      flood = 1'b0;
      drain();
    end

    $display("%0d requests sent, %0d results checked, %0d remixes", sent, seen, remixes);
    $display("mired limits swept incl. crossed and full range, with idle and flood phases");
    if (errors == 0) $display("led_cct_fade_mixer_test: PASS");
    else $display("led_cct_fade_mixer_test: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/lcfm_pkg.sv
sv/lcfm_if.sv
sv/lcfm_front.sv
sv/lcfm_div.sv
sv/lcfm_back.sv
sv/led_cct_fade_mixer.sv
sim/led_cct_fade_mixer_test.sv
